FILE: hw/rtl/emdc_pkg.sv
// shared types, constants and helper functions of the encoder menu pot controller
// no dependencies
`default_nettype none

package emdc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd2;

    localparam logic [7:0]  SETTLE_RST = 8'd5;
    localparam logic [15:0] SHORT_RST  = 16'd50;
    localparam logic [15:0] LONG_RST   = 16'd1000;

    // quadrature codes, {a, b}
    localparam logic [1:0] QUAD_00 = 2'b00;
    localparam logic [1:0] QUAD_01 = 2'b01;
    localparam logic [1:0] QUAD_11 = 2'b11;
    localparam logic [1:0] QUAD_10 = 2'b10;

    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [7:0]  CMD_WIPER_WRITE = 8'h00;
    localparam logic [8:0]  VALUE_MAX       = 9'd255;
    localparam logic [8:0]  VALUE_TOP       = 9'd256;

    // what one accepted sample asks of the menu sequencer
    typedef struct packed {
        logic restore;
        logic edit_go;
        logic up;
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDIT,
        ST_EMIT,
        ST_SW_RD,
        ST_SW_OUT
    } t_state;

    // next state of a clockwise gray step
    function automatic logic [1:0] cw_next(input logic [1:0] q);
        logic [1:0] r;
        case (q)
            QUAD_00: r = QUAD_01;
            QUAD_01: r = QUAD_11;
            QUAD_11: r = QUAD_10;
            QUAD_10: r = QUAD_00;
            default: r = QUAD_00;
        endcase
        return r;
    endfunction

    // power-on value of a pot
    function automatic logic [8:0] pot_default(input logic [7:0] idx);
        logic [8:0] r;
        if (idx >= 8'd6) begin
            r = VALUE_TOP;
        end else begin
            r = 9'(9'd4 << idx);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/encoder_menu_digipot_controller.sv
// Rotary encoder menu controller for a bank of digital potentiometers.
// Input channel (i_valid/o_ready): one word per millisecond sample of the encoder
// pins and the push switch. Output channel (o_valid/i_ready): pot write words,
// one per sample normally, POT_COUNT words in pot order after a long press.
// Every sample gives at least one word; o_last marks the final word of a sample.
// Configuration: i_cfg_we writes register i_cfg_idx (0 settle, 1 short press,
// 2 long press) with i_cfg_data; the user must write only while the block is
// idle, the block itself does not enforce it. A sample's first word passes the
// edit and emit states, or edit, sweep read and sweep out for a restore sweep,
// before it reaches the output register. A restore sweep sends one pot per cycle
// while the receiver takes words, set by the single read port of the pot value
// store. One sample is worked on at a time.
// The next sample is taken once the last word sits in the output register.
// Reset: all pots return to their defaults at once through per-entry valid bits,
// pot select mode, pot 0 selected, registers at their default values.
// A stalled receiver holds the output word and the sequencer waits for it.
// depends on emdc_pkg, emdc_front, emdc_menu
`default_nettype none

module encoder_menu_digipot_controller import emdc_pkg::*; #(
    parameter int POT_COUNT = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_quad_a,
    input  wire logic                  i_quad_b,
    input  wire logic                  i_switch_level,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_write_valid,
    output logic      [2:0]            o_write_pot,
    output logic      [7:0]            o_command_byte,
    output logic      [7:0]            o_wiper_byte,
    output logic      [8:0]            o_pot_value,
    output logic                       o_value_mode,
    output logic                       o_led_on,
    output logic      [2:0]            o_active_pot,
    output logic                       o_last
);

    localparam int PW = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;

    t_event        ev;
    logic [PW-1:0] sel;
    logic          edit_mode;
    logic [PW-1:0] current_pot;
    logic          idle;
    logic          accept;

    // input handshake
    assign o_ready = idle;
    assign accept  = i_valid && idle;

    emdc_front #(
        .POT_COUNT (POT_COUNT),
        .PW        (PW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_quad_a       (i_quad_a),
        .i_quad_b       (i_quad_b),
        .i_switch_level (i_switch_level),
        .o_event        (ev),
        .o_sel          (sel),
        .o_edit_mode    (edit_mode),
        .o_current_pot  (current_pot)
    );

    emdc_menu #(
        .POT_COUNT (POT_COUNT),
        .PW        (PW)
    ) u_menu (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_event        (ev),
        .i_sel          (sel),
        .i_edit_mode    (edit_mode),
        .i_current_pot  (current_pot),
        .o_idle         (idle),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_valid  (o_write_valid),
        .o_write_pot    (o_write_pot),
        .o_pot_value    (o_pot_value),
        .o_value_mode   (o_value_mode),
        .o_active_pot   (o_active_pot),
        .o_last         (o_last)
    );

    // serial bytes and mode led
    assign o_command_byte = CMD_WIPER_WRITE;
    assign o_wiper_byte   = 8'(VALUE_TOP - o_pot_value);
    assign o_led_on       = ~o_value_mode;

endmodule

`default_nettype wire

FILE: hw/rtl/emdc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module emdc_ram #(
    parameter int W  = 9,
    parameter int D  = 7,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/emdc_front.sv
// encoder decode, press timing, mode and pot selection, configuration registers
// depends on emdc_pkg
`default_nettype none

module emdc_front import emdc_pkg::*; #(
    parameter int POT_COUNT = 7,
    parameter int PW        = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic                  i_quad_a,
    input  wire logic                  i_quad_b,
    input  wire logic                  i_switch_level,
    output t_event                     o_event,
    output logic      [PW-1:0]         o_sel,
    output logic                       o_edit_mode,
    output logic      [PW-1:0]         o_current_pot
);

    logic [7:0]    r_settle;
    logic [15:0]   r_short;
    logic [15:0]   r_long;
    logic [1:0]    r_prev;
    logic [15:0]   r_quiet;
    logic          r_timing;
    logic [15:0]   r_pc;
    logic          r_long_done;
    logic          r_edit_mode;
    logic [PW-1:0] r_current_pot;

    logic [1:0]    quad;
    logic [15:0]   quiet_inc;
    logic          change;
    logic          up;
    logic          pressed;
    logic [15:0]   pc_inc;
    logic [15:0]   pc_eff;
    logic          restore;
    logic          toggle;
    logic [PW-1:0] pot_up;
    logic [PW-1:0] pot_dn;

    // encoder change detect with settle time
    always_comb begin
        quad      = {i_quad_a, i_quad_b};
        quiet_inc = (r_quiet != COUNT_MAX) ? r_quiet + 16'd1 : r_quiet;
        change    = (quad != r_prev) && (quiet_inc > {8'h00, r_settle});
        up        = (cw_next(r_prev) == quad);
    end

    // press timing, short and long press
    always_comb begin
        pressed = ~i_switch_level;
        pc_inc  = (r_timing && (r_pc != COUNT_MAX)) ? r_pc + 16'd1 : r_pc;
        pc_eff  = (pressed && !r_timing) ? 16'd0 : pc_inc;
        restore = pressed && !r_long_done && (pc_eff > r_long);
        toggle  = !pressed && r_timing && !r_long_done && (pc_inc > r_short);
    end

    // pot selection with wrap
    always_comb begin
        pot_up = (r_current_pot == PW'(POT_COUNT - 1)) ? '0 : r_current_pot + PW'(1);
        pot_dn = (r_current_pot == '0) ? PW'(POT_COUNT - 1) : r_current_pot - PW'(1);
    end

    assign o_event.restore = restore;
    assign o_event.edit_go = change && !toggle && r_edit_mode;
    assign o_event.up      = up;
    assign o_sel           = r_current_pot;
    assign o_edit_mode     = r_edit_mode;
    assign o_current_pot   = r_current_pot;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_RST;
            r_short  <= SHORT_RST;
            r_long   <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETTLE: r_settle <= i_cfg_data[7:0];
                CFG_SHORT:  r_short  <= i_cfg_data;
                CFG_LONG:   r_long   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // sample state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= QUAD_00;
            r_quiet       <= '0;
            r_timing      <= 1'b0;
            r_pc          <= '0;
            r_long_done   <= 1'b0;
            r_edit_mode   <= 1'b0;
            r_current_pot <= '0;
        end else if (i_accept) begin
            r_prev      <= change ? quad : r_prev;
            r_quiet     <= change ? 16'd0 : quiet_inc;
            r_timing    <= pressed;
            r_pc        <= pc_eff;
            r_long_done <= pressed && (r_long_done || restore);
            if (toggle) begin
                r_edit_mode <= ~r_edit_mode;
            end else if (change && !r_edit_mode) begin
                r_current_pot <= up ? pot_up : pot_dn;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/emdc_menu.sv
// pot value store, edit read-modify-write, restore sweep and output register
// depends on emdc_pkg and emdc_ram
`default_nettype none

module emdc_menu import emdc_pkg::*; #(
    parameter int POT_COUNT = 7,
    parameter int PW        = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire t_event        i_event,
    input  wire logic [PW-1:0] i_sel,
    input  wire logic          i_edit_mode,
    input  wire logic [PW-1:0] i_current_pot,
    output logic               o_idle,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_write_valid,
    output logic      [2:0]    o_write_pot,
    output logic      [8:0]    o_pot_value,
    output logic               o_value_mode,
    output logic      [2:0]    o_active_pot,
    output logic               o_last
);

    t_state                 r_state, n_state;
    t_event                 r_ev, n_ev;
    logic [PW-1:0]          r_sel, n_sel;
    logic [PW-1:0]          r_idx, n_idx;
    logic [POT_COUNT-1:0]   r_valid, n_valid;
    logic                   r_p_write, n_p_write;
    logic [8:0]             r_p_value, n_p_value;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_write, n_out_write;
    logic [2:0]             r_out_pot, n_out_pot;
    logic [8:0]             r_out_value, n_out_value;
    logic                   r_out_mode, n_out_mode;
    logic [2:0]             r_out_sel, n_out_sel;
    logic                   r_out_last, n_out_last;

    logic                   ram_we;
    logic [PW-1:0]          ram_raddr;
    logic [8:0]             ram_rdata;
    logic                   out_free;
    logic [8:0]             cur_v;
    logic [8:0]             edit_v;
    logic                   edit_ok;
    logic [8:0]             sw_v;
    logic                   sw_last;
    logic [7:0]             sel_wide;
    logic [7:0]             idx_wide;
    logic [7:0]             cur_wide;

    emdc_ram #(
        .W  (9),
        .D  (POT_COUNT),
        .AW (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_sel),
        .i_wdata (edit_v),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // stored value of the selected pot, its edited value, and the sweep value of pot r_idx
    always_comb begin
        sel_wide = 8'(r_sel);
        idx_wide = 8'(r_idx);
        cur_wide = 8'(i_current_pot);
        cur_v    = r_valid[r_sel] ? ram_rdata : pot_default(sel_wide);
        edit_v   = cur_v;
        edit_ok  = 1'b0;
        if (r_ev.up) begin
            if (cur_v < VALUE_MAX) begin
                edit_v  = cur_v + 9'd1;
                edit_ok = 1'b1;
            end
        end else if ((cur_v != 9'd0) && (cur_v <= VALUE_TOP)) begin
            edit_v  = cur_v - 9'd1;
            edit_ok = 1'b1;
        end
        sw_v    = r_valid[r_idx] ? ram_rdata : pot_default(idx_wide);
        sw_last = (r_idx == PW'(POT_COUNT - 1));
    end

    // sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_ev        = r_ev;
        n_sel       = r_sel;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_p_write   = r_p_write;
        n_p_value   = r_p_value;
        n_out_valid = r_out_valid;
        n_out_write = r_out_write;
        n_out_pot   = r_out_pot;
        n_out_value = r_out_value;
        n_out_mode  = r_out_mode;
        n_out_sel   = r_out_sel;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;
        out_free    = !r_out_valid || i_ready;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                ram_raddr = i_sel;
                if (i_accept) begin
                    n_ev    = i_event;
                    n_sel   = i_sel;
                    n_state = ST_EDIT;
                    if (i_event.restore) begin
                        n_valid = '0;
                    end
                end
            end
            ST_EDIT: begin
                if (r_ev.edit_go && edit_ok) begin
                    ram_we         = 1'b1;
                    n_valid[r_sel] = 1'b1;
                end
                n_p_write = r_ev.edit_go && edit_ok;
                n_p_value = edit_v;
                n_idx     = '0;
                n_state   = r_ev.restore ? ST_SW_RD : ST_EMIT;
            end
            ST_SW_RD: begin
                n_state = ST_SW_OUT;
            end
            ST_SW_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_write = 1'b1;
                    n_out_pot   = idx_wide[2:0];
                    n_out_value = sw_v;
                    n_out_mode  = i_edit_mode;
                    n_out_sel   = cur_wide[2:0];
                    n_out_last  = sw_last;
                    if (sw_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx     = r_idx + PW'(1);
                        ram_raddr = r_idx + PW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_write = r_p_write;
                    n_out_pot   = r_p_write ? sel_wide[2:0] : 3'd0;
                    n_out_value = r_p_write ? r_p_value : 9'd0;
                    n_out_mode  = i_edit_mode;
                    n_out_sel   = cur_wide[2:0];
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ev        <= n_ev;
        r_sel       <= n_sel;
        r_p_write   <= n_p_write;
        r_p_value   <= n_p_value;
        r_out_write <= n_out_write;
        r_out_pot   <= n_out_pot;
        r_out_value <= n_out_value;
        r_out_mode  <= n_out_mode;
        r_out_sel   <= n_out_sel;
        r_out_last  <= n_out_last;
    end

    assign o_idle        = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_write_valid = r_out_write;
    assign o_write_pot   = r_out_pot;
    assign o_pot_value   = r_out_value;
    assign o_value_mode  = r_out_mode;
    assign o_active_pot  = r_out_sel;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

FILE: hw/rtl/emdc_checker.sv
// port-level checks of the encoder menu pot controller, bound to the top level
// depends on emdc_pkg and encoder_menu_digipot_controller
`default_nettype none

module emdc_checker import emdc_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_ready,
    input wire logic       o_write_valid,
    input wire logic [7:0] o_wiper_byte,
    input wire logic [8:0] o_pot_value,
    input wire logic [2:0] o_write_pot,
    input wire logic       o_value_mode,
    input wire logic       o_led_on,
    input wire logic       o_last
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pot_value) && $stable(o_last))
        else $error("output word changed while stalled");

    // a word without pot write is blank and the last word of its sample
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_valid |-> o_last && (o_pot_value == 9'd0)
            && (o_write_pot == 3'd0))
        else $error("no-write word not blank or not last");

    // wiper byte follows the stored value
    a_wiper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_wiper_byte == 8'(VALUE_TOP - o_pot_value))
        else $error("wiper byte mismatch");

    // led shows pot select mode
    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_led_on != o_value_mode)
        else $error("led and mode disagree");

    // no new sample while a sweep word is pending that is not last
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input taken during a restore sweep");

endmodule

bind encoder_menu_digipot_controller emdc_checker u_emdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_ready       (o_ready),
    .o_write_valid (o_write_valid),
    .o_wiper_byte  (o_wiper_byte),
    .o_pot_value   (o_pot_value),
    .o_write_pot   (o_write_pot),
    .o_value_mode  (o_value_mode),
    .o_led_on      (o_led_on),
    .o_last        (o_last)
);

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench of encoder_menu_digipot_controller: directed and random encoder
// samples, predicted pot write words checked field by field against the output channel
// depends on emdc_pkg and the rtl of encoder_menu_digipot_controller
module testbench;
    import emdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POTS = 7;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_PAUSE = 12;
    localparam int PRESSURE_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] quad;
        logic       sw;
    } t_sample;

    typedef struct packed {
        logic       write_valid;
        logic [2:0] write_pot;
        logic [7:0] command_byte;
        logic [7:0] wiper_byte;
        logic [8:0] pot_value;
        logic       value_mode;
        logic       led_on;
        logic [2:0] active_pot;
        logic       last;
    } t_pot_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  i_quad_a = 1'b0;
    logic                  i_quad_b = 1'b0;
    logic                  i_switch_level = 1'b1;
    logic                  i_ready = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic                  o_write_valid;
    logic [2:0]            o_write_pot;
    logic [7:0]            o_command_byte;
    logic [7:0]            o_wiper_byte;
    logic [8:0]            o_pot_value;
    logic                  o_value_mode;
    logic                  o_led_on;
    logic [2:0]            o_active_pot;
    logic                  o_last;

    // samples waiting for the driver, words waiting for the output channel
    t_sample   sample_q[$];
    t_pot_word words_due[$];
    int        queued_total = 0;
    int        err_count = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    logic      in_fire = 1'b0;
    logic      pressure_go = 1'b0;
    logic      pressure_done = 1'b0;
    logic [1:0] pins_q = QUAD_00;

    // predictor state and register copies
    logic [7:0]  cfg_settle;
    logic [15:0] cfg_short;
    logic [15:0] cfg_long;
    logic [1:0]  enc_prev;
    logic [15:0] enc_quiet;
    logic        sw_timing;
    logic [15:0] sw_count;
    logic        sw_long_seen;
    logic        edit_on;
    logic [2:0]  sel_pot;
    logic [8:0]  pot_val[POTS];

    encoder_menu_digipot_controller #(.POT_COUNT(POTS)) dut (.*);

    always #1 i_clk = ~i_clk;

    // gray code walk of the quadrature pins, {a, b}
    function automatic logic [1:0] gray_fwd(input logic [1:0] q);
        return {q[0], ~q[1]};
    endfunction

    function automatic logic [1:0] gray_back(input logic [1:0] q);
        return {~q[0], q[1]};
    endfunction

    function automatic logic [8:0] factory_value(input int idx);
        return (idx >= 6) ? VALUE_TOP : 9'(4 << idx);
    endfunction

    task automatic model_reset();
        cfg_settle = SETTLE_RST;
        cfg_short = SHORT_RST;
        cfg_long = LONG_RST;
        enc_prev = QUAD_00;
        enc_quiet = '0;
        sw_timing = 1'b0;
        sw_count = '0;
        sw_long_seen = 1'b0;
        edit_on = 1'b0;
        sel_pot = '0;
        for (int k = 0; k < POTS; k++) pot_val[k] = factory_value(k);
    endtask

    task automatic push_word(input logic wr, input logic [2:0] idx, input logic [8:0] value,
                             input logic is_last);
        t_pot_word w;
        w.write_valid = wr;
        w.write_pot = wr ? idx : 3'd0;
        w.command_byte = CMD_WIPER_WRITE;
        w.wiper_byte = wr ? 8'(VALUE_TOP - value) : 8'd0;
        w.pot_value = wr ? value : 9'd0;
        w.value_mode = edit_on;
        w.led_on = !edit_on;
        w.active_pot = sel_pot;
        w.last = is_last;
        words_due.push_back(w);
    endtask

    // expected words of one accepted sample
    task automatic predict_sample(input logic qa, input logic qb, input logic sw);
        logic [1:0] quad;
        logic       step_up;
        logic       step_dn;
        logic       restore;
        logic       toggle;
        logic       edited;
        logic [2:0] at;
        quad = {qa, qb};
        step_up = 1'b0;
        step_dn = 1'b0;
        restore = 1'b0;
        toggle = 1'b0;
        edited = 1'b0;
        at = sel_pot;

        // encoder with settle time
        if (enc_quiet != COUNT_MAX) enc_quiet = enc_quiet + 16'd1;
        if (quad != enc_prev && enc_quiet > 16'(cfg_settle)) begin
            if (quad == gray_fwd(enc_prev)) step_up = 1'b1;
            else step_dn = 1'b1;
            enc_prev = quad;
            enc_quiet = '0;
        end

        // push switch timing
        if (sw_timing && sw_count != COUNT_MAX) sw_count = sw_count + 16'd1;
        if (!sw) begin
            if (!sw_timing) begin
                sw_timing = 1'b1;
                sw_count = '0;
            end
            if (!sw_long_seen && sw_count > cfg_long) begin
                restore = 1'b1;
                sw_long_seen = 1'b1;
            end
        end else begin
            if (sw_timing && !sw_long_seen && sw_count > cfg_short) toggle = 1'b1;
            sw_timing = 1'b0;
            sw_long_seen = 1'b0;
        end

        // menu
        if (restore) begin
            for (int k = 0; k < POTS; k++) pot_val[k] = factory_value(k);
        end
        if (toggle) begin
            edit_on = !edit_on;
        end else if (edit_on) begin
            if (step_up && pot_val[at] < VALUE_MAX) begin
                pot_val[at] = pot_val[at] + 9'd1;
                edited = 1'b1;
            end else if (step_dn && pot_val[at] != 9'd0) begin
                pot_val[at] = pot_val[at] - 9'd1;
                edited = 1'b1;
            end
        end else if (step_up) begin
            sel_pot = (at == POTS - 1) ? 3'd0 : at + 3'd1;
        end else if (step_dn) begin
            sel_pot = (at == 0) ? 3'(POTS - 1) : at - 3'd1;
        end

        if (restore) begin
            for (int k = 0; k < POTS; k++) push_word(1'b1, 3'(k), pot_val[k], k == POTS - 1);
        end else if (edited) begin
            push_word(1'b1, at, pot_val[at], 1'b1);
        end else begin
            push_word(1'b0, 3'd0, 9'd0, 1'b1);
        end
    endtask

    task automatic note_error(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) note_error($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // predict on input words, check output words, predict first
    always @(posedge i_clk) begin
        t_pot_word got;
        t_pot_word want;
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_sample(i_quad_a, i_quad_b, i_switch_level);
            if (o_valid && i_ready) begin
                got = '{o_write_valid, o_write_pot, o_command_byte, o_wiper_byte,
                        o_pot_value, o_value_mode, o_led_on, o_active_pot, o_last};
                if (words_due.size() == 0) begin
                    note_error("word with nothing expected");
                end else begin
                    want = words_due.pop_front();
                    check_field("write_valid", got.write_valid, want.write_valid);
                    check_field("write_pot", got.write_pot, want.write_pot);
                    check_field("command_byte", got.command_byte, want.command_byte);
                    check_field("wiper_byte", got.wiper_byte, want.wiper_byte);
                    check_field("pot_value", got.pot_value, want.pot_value);
                    check_field("value_mode", got.value_mode, want.value_mode);
                    check_field("led_on", got.led_on, want.led_on);
                    check_field("active_pot", got.active_pot, want.active_pot);
                    check_field("last", got.last, want.last);
                end
            end
        end
    end

    // input driver, holds a word until it is taken
    always @(negedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = sample_q.pop_front();
                i_valid <= 1'b1;
                i_quad_a <= nxt.quad[1];
                i_quad_b <= nxt.quad[0];
                i_switch_level <= nxt.sw;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output ready, random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (pressure_go && !pressure_done) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        wait (pressure_go);
        repeat (PRESSURE_CYCLES) @(posedge i_clk);
        pressure_done = 1'b1;
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        case (idx)
            CFG_SETTLE: cfg_settle = data[7:0];
            CFG_SHORT:  cfg_short = data;
            CFG_LONG:   cfg_long = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic setup_regs(input logic [15:0] settle, input logic [15:0] short_ms,
                              input logic [15:0] long_ms, input int tx, input int rx);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_SHORT, short_ms);
        write_reg(CFG_LONG, long_ms);
        @(posedge i_clk);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
    endtask

    // wait until every word is out, then let the block go quiet
    task automatic drain();
        while (sample_q.size() != 0 || i_valid || words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic sw);
        sample_q.push_back('{pins_q, sw});
        queued_total++;
    endtask

    task automatic hold_pins(input int n, input logic sw);
        for (int k = 0; k < n; k++) queue_sample(sw);
    endtask

    task automatic step_pins(input bit up);
        pins_q = up ? gray_fwd(pins_q) : gray_back(pins_q);
    endtask

    // held press, optional encoder motion while held and on release
    task automatic press_for(input int p, input bit wiggle, input bit turn_on_release);
        int at;
        at = wiggle ? int'($urandom_range(0, p - 1)) : -1;
        for (int k = 0; k < p; k++) begin
            if (k == at) step_pins($urandom_range(1));
            queue_sample(1'b0);
        end
        if (turn_on_release) step_pins($urandom_range(1));
        queue_sample(1'b1);
    endtask

    // mostly well formed turns and presses, some noise
    task automatic wander(input int n);
        int goal;
        int pick;
        int steps;
        int hold;
        int p;
        bit up;
        goal = queued_total + n;
        while (queued_total < goal) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                up = $urandom_range(1);
                steps = $urandom_range(1, 8);
                for (int s = 0; s < steps; s++) begin
                    hold = (cfg_settle > 6) ? int'($urandom_range(1, 4))
                                            : int'(cfg_settle) + 1 + int'($urandom_range(1));
                    if ($urandom_range(7) == 0) hold = $urandom_range(1, hold);
                    step_pins(up);
                    queue_sample(1'b1);
                    hold_pins(hold - 1, 1'b1);
                end
            end else if (pick < 75) begin
                case ($urandom_range(2))
                    0: p = (cfg_short == 0) ? 1
                           : int'($urandom_range(1, (cfg_short > 40) ? 40 : int'(cfg_short)));
                    1: p = int'(cfg_short) + 1 + int'($urandom_range(2));
                    default: p = int'(cfg_long) + 2 + int'($urandom_range(3));
                endcase
                if (p > 60) p = 60;
                press_for(p, $urandom_range(3) == 0, $urandom_range(3) == 0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    pins_q = 2'($urandom_range(3));
                    queue_sample($urandom_range(1));
                end
            end else begin
                hold_pins($urandom_range(1, 6), 1'b1);
            end
        end
    endtask

    initial begin
        model_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // directed: fast settle, short presses, unused register index
        setup_regs(16'd0, 16'd1, 16'd4, 0, 0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        @(posedge i_clk);
        queue_sample(1'b1);
        step_pins(1'b0);
        queue_sample(1'b1);                 // select wraps down to the top pot
        press_for(2, 1'b0, 1'b0);           // into value edit
        step_pins(1'b1);
        queue_sample(1'b1);                 // stored 256 cannot go up
        step_pins(1'b0);
        queue_sample(1'b1);                 // 256 down to 255
        step_pins(1'b1);
        queue_sample(1'b1);                 // 255 is the ceiling
        hold_pins(5, 1'b0);                 // long press, edit on the restore sample
        step_pins(1'b0);
        queue_sample(1'b0);
        queue_sample(1'b1);
        press_for(2, 1'b0, 1'b1);           // toggle back, motion on release ignored
        pins_q = pins_q ^ 2'b11;
        queue_sample(1'b1);                 // jump over a state reads as down
        step_pins(1'b1);
        queue_sample(1'b1);
        step_pins(1'b1);
        queue_sample(1'b1);                 // select wraps up to pot 0
        press_for(2, 1'b0, 1'b0);
        repeat (5) begin                    // pot 0 down to 0 and held there
            step_pins(1'b0);
            queue_sample(1'b1);
        end
        drain();

        // sender idling
        setup_regs(16'd2, 16'd3, 16'd12, 54, 0);
        wander(100);
        drain();

        // receiver stalling, long hold-off first so the block backs up
        setup_regs(16'd1, 16'd2, 16'd8, 0, 54);
        pressure_go = 1'b1;
        wander(100);
        drain();

        // zero press times, settle written with junk high bits
        setup_regs(16'hA503, 16'd0, 16'd0, 23, 23);
        wander(70);
        drain();

        // top of every register
        setup_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
        wander(30);
        drain();

        // reset values
        setup_regs(16'(SETTLE_RST), SHORT_RST, LONG_RST, 23, 23);
        wander(40);
        drain();

        if (err_count == 0 && words_due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: encoder_menu_digipot_controller.f
hw/rtl/emdc_pkg.sv
hw/rtl/emdc_ram.sv
hw/rtl/emdc_front.sv
hw/rtl/emdc_menu.sv
hw/rtl/encoder_menu_digipot_controller.sv
hw/rtl/emdc_checker.sv
dv/testbench.sv
